// ===== hdl/srocu_pkg.sv =====
// shared types and constants for the segment raster overlap counter
`default_nettype none

package srocu_pkg;

    // field widths
    localparam int COORD_W = 10;
    localparam int TOTAL_W = 21;
    localparam int MARK_W  = 11;
    localparam int CELL_W  = 2;
    localparam int THR_W   = 2;

    // packed stream widths, whole bytes
    localparam int IN_W  = 40;
    localparam int OUT_W = 40;

    // coverage counter limit and threshold after reset
    localparam logic [CELL_W-1:0] CELL_MAX   = 2'd3;
    localparam logic [THR_W-1:0]  THR_RESET  = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;        // take the request and set up the walk
        logic step;        // issue the current cell and move on
        logic clear_step;  // write one zero entry of the grid store
        logic out_load;    // move the result into the output register
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic in_reject;   // request on the input is not a straight or diagonal line
        logic walk_last;   // current cell is the last of the segment
        logic clear_last;  // clearing pass is on its final entry
        logic out_free;    // output register can take a result this cycle
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/segment_raster_overlap_counter_unit.sv =====
// top level of the segment raster overlap counter
//
//  channel   | direction | signals                         | contents
//  ----------+-----------+---------------------------------+--------------------------------
//  s_axis    | in        | s_tvalid, s_tready, s_tdata     | one segment request
//  m_axis    | out       | m_tvalid, m_tready, m_tdata     | one result per request
//  config    | in        | cfg_we, cfg_wdata               | overlap threshold
//
//  An accepted segment is walked one grid cell per cycle through the read-modify-write of the
//  grid store (registered read on one port, write on the other), then drains into the result
//  register; a rejected segment goes straight to the result register. Up to 1024 cells.
//  After reset a clearing pass writes every grid entry once: 2^(2*min(clog2(GRID_SIDE),10))
//  entries (1048576 at the default), during which s_tready stays low.
//  A new request is taken while the previous result waits in the output register; a result
//  that cannot leave holds the controller until m_tready.
`default_nettype none

module segment_raster_overlap_counter_unit #(
    parameter int GRID_SIDE = 1024
) (
    input  wire                          clk,
    input  wire                          rst_n,
    // start_x, start_y, end_x, end_y (10 bits each) from bit 0 up
    input  wire  [srocu_pkg::IN_W-1:0]   s_tdata,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // overlap_cells (21), cells_marked (11), segment_rejected (1), zero pad, from bit 0 up
    output logic [srocu_pkg::OUT_W-1:0]  m_tdata,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    input  wire                          cfg_we,
    input  wire  [srocu_pkg::THR_W-1:0]  cfg_wdata
);
    import srocu_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencing
    srocu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // walker, grid store and result
    srocu_datapath #(
        .GRID_SIDE (GRID_SIDE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== hdl/srocu_ctrl.sv =====
// controller state machine for the segment raster overlap counter
`default_nettype none

module srocu_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    input  srocu_pkg::status_t status,
    output srocu_pkg::cmd_t    cmd
);
    import srocu_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_WALK   = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.in_reject ? ST_RESULT : ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.step = 1'b1;
                if (status.walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last cell finishes its write this cycle
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/srocu_datapath.sv =====
// datapath: segment walker, grid store read-modify-write, counters and result register
`default_nettype none

module srocu_datapath #(
    parameter int GRID_SIDE = 1024
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  srocu_pkg::cmd_t               cmd,
    output srocu_pkg::status_t            status,
    input  wire  [srocu_pkg::IN_W-1:0]    in_data,
    input  wire                           cfg_we,
    input  wire  [srocu_pkg::THR_W-1:0]   cfg_wdata,
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic [srocu_pkg::OUT_W-1:0]   out_data
);
    import srocu_pkg::*;

    localparam int SIDE_LOG = $clog2(GRID_SIDE);
    localparam int SIDE_AW  = (SIDE_LOG > COORD_W) ? COORD_W : SIDE_LOG;
    localparam int ADDR_W   = 2 * SIDE_AW;
    localparam int DEPTH    = 1 << ADDR_W;

    // request fields
    logic [COORD_W-1:0] in_x0, in_y0, in_x1, in_y1;
    logic [COORD_W-1:0] in_dx, in_dy, in_len;
    logic               in_reject;

    assign in_x0 = in_data[COORD_W-1:0];
    assign in_y0 = in_data[2*COORD_W-1:COORD_W];
    assign in_x1 = in_data[3*COORD_W-1:2*COORD_W];
    assign in_y1 = in_data[4*COORD_W-1:3*COORD_W];

    // segment shape
    always_comb
    begin
        in_dx     = (in_x0 > in_x1) ? (in_x0 - in_x1) : (in_x1 - in_x0);
        in_dy     = (in_y0 > in_y1) ? (in_y0 - in_y1) : (in_y1 - in_y0);
        in_len    = (in_dx > in_dy) ? in_dx : in_dy;
        in_reject = (in_dx != '0) && (in_dy != '0) && (in_dx != in_dy);
    end

    // walker registers
    logic [COORD_W-1:0] cur_x_reg, cur_x_next;
    logic [COORD_W-1:0] cur_y_reg, cur_y_next;
    logic [COORD_W-1:0] remain_reg, remain_next;
    logic               x_inc_reg, x_inc_next, x_dec_reg, x_dec_next;
    logic               y_inc_reg, y_inc_next, y_dec_reg, y_dec_next;
    logic               rej_reg, rej_next;

    // threshold and counters
    logic [THR_W-1:0]   thr_reg, thr_next;
    logic [CELL_W-1:0]  thr_eff;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [MARK_W-1:0]  marked_reg, marked_next;

    // cell pipeline between address issue and write back
    logic               p_valid_reg, p_valid_next;
    logic               p_in_grid_reg, p_in_grid_next;
    logic [ADDR_W-1:0]  p_addr_reg, p_addr_next;
    logic [ADDR_W-1:0]  rd_addr;
    logic               cur_in_grid;

    // clearing pass
    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;

    // grid store
    logic [CELL_W-1:0]  mem [DEPTH];
    logic [CELL_W-1:0]  rd_data_reg;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [CELL_W-1:0]  wr_data;
    logic [CELL_W-1:0]  cell_inc;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [TOTAL_W-1:0] out_total_reg, out_total_next;
    logic [MARK_W-1:0]  out_marked_reg, out_marked_next;
    logic               out_rej_reg, out_rej_next;

    assign thr_eff     = (thr_reg == '0) ? 2'd1 : thr_reg;
    assign cur_in_grid = (32'(cur_x_reg) < 32'(GRID_SIDE)) && (32'(cur_y_reg) < 32'(GRID_SIDE));
    assign rd_addr     = {cur_y_reg[SIDE_AW-1:0], cur_x_reg[SIDE_AW-1:0]};
    assign cell_inc    = rd_data_reg + 2'd1;

    assign status.in_reject  = in_reject;
    assign status.walk_last  = (remain_reg == '0);
    assign status.clear_last = (clr_cnt_reg == {ADDR_W{1'b1}});
    assign status.out_free   = !out_valid_reg || out_ready;

    // walker and issue stage
    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        remain_next    = remain_reg;
        x_inc_next     = x_inc_reg;
        x_dec_next     = x_dec_reg;
        y_inc_next     = y_inc_reg;
        y_dec_next     = y_dec_reg;
        rej_next       = rej_reg;
        p_valid_next   = cmd.step;
        p_in_grid_next = cur_in_grid;
        p_addr_next    = rd_addr;
        if (cmd.load)
        begin
            cur_x_next  = in_x0;
            cur_y_next  = in_y0;
            remain_next = in_len;
            x_inc_next  = in_x1 > in_x0;
            x_dec_next  = in_x1 < in_x0;
            y_inc_next  = in_y1 > in_y0;
            y_dec_next  = in_y1 < in_y0;
            rej_next    = in_reject;
        end
        else if (cmd.step)
        begin
            if (x_inc_reg)
            begin
                cur_x_next = cur_x_reg + 1'b1;
            end
            else if (x_dec_reg)
            begin
                cur_x_next = cur_x_reg - 1'b1;
            end
            if (y_inc_reg)
            begin
                cur_y_next = cur_y_reg + 1'b1;
            end
            else if (y_dec_reg)
            begin
                cur_y_next = cur_y_reg - 1'b1;
            end
            remain_next = remain_reg - 1'b1;
        end
    end

    // write-back stage, clearing pass and threshold
    always_comb
    begin
        total_next   = total_reg;
        marked_next  = marked_reg;
        thr_next     = cfg_we ? cfg_wdata : thr_reg;
        clr_cnt_next = clr_cnt_reg;
        wr_en        = 1'b0;
        wr_addr      = p_addr_reg;
        wr_data      = cell_inc;
        if (cmd.clear_step)
        begin
            wr_en        = 1'b1;
            wr_addr      = clr_cnt_reg;
            wr_data      = '0;
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
        else if (p_valid_reg && p_in_grid_reg)
        begin
            marked_next = marked_reg + 1'b1;
            if (rd_data_reg != CELL_MAX)
            begin
                wr_en = 1'b1;
                if (cell_inc == thr_eff)
                begin
                    total_next = total_reg + 1'b1;
                end
            end
        end
        if (cmd.load)
        begin
            marked_next = '0;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        out_total_next  = out_total_reg;
        out_marked_next = out_marked_reg;
        out_rej_next    = out_rej_reg;
        if (cmd.out_load)
        begin
            out_valid_next  = 1'b1;
            out_total_next  = total_reg;
            out_marked_next = marked_reg;
            out_rej_next    = rej_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THR_RESET;
            total_reg     <= '0;
            clr_cnt_reg   <= '0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            thr_reg       <= thr_next;
            total_reg     <= total_next;
            clr_cnt_reg   <= clr_cnt_next;
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_x_reg      <= cur_x_next;
        cur_y_reg      <= cur_y_next;
        remain_reg     <= remain_next;
        x_inc_reg      <= x_inc_next;
        x_dec_reg      <= x_dec_next;
        y_inc_reg      <= y_inc_next;
        y_dec_reg      <= y_dec_next;
        rej_reg        <= rej_next;
        marked_reg     <= marked_next;
        p_in_grid_reg  <= p_in_grid_next;
        p_addr_reg     <= p_addr_next;
        out_total_reg  <= out_total_next;
        out_marked_reg <= out_marked_next;
        out_rej_reg    <= out_rej_next;
    end

    // grid store, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{(OUT_W - TOTAL_W - MARK_W - 1){1'b0}},
                        out_rej_reg, out_marked_reg, out_total_reg};

endmodule

`default_nettype wire

// ===== sim/tb_segment_raster_overlap_counter_unit.sv =====
// testbench for the segment raster overlap counter: request driver, line predictor, result checker
module tb_segment_raster_overlap_counter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import srocu_pkg::*;

    localparam int GRID_SIDE      = 1024;
    localparam int COORD_MAX      = (1 << COORD_W) - 1;
    localparam int WATCHDOG_LIMIT = 3_500_000;
    localparam int DRAIN_CYCLES   = 1100;
    localparam int REPORT_LIMIT   = 10;
    localparam int HOLDOFF_CYCLES = 400;

    // one segment request, start_x in the lowest bits
    typedef struct packed {
        logic [COORD_W-1:0] end_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] start_x;
    } segment_t;

    // one result, overlap_cells in the lowest bits
    typedef struct packed {
        logic               segment_rejected;
        logic [MARK_W-1:0]  cells_marked;
        logic [TOTAL_W-1:0] overlap_cells;
    } tally_t;

    typedef enum {SINK_FREE, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic [IN_W-1:0]   s_tdata   = '0;   // start_x, start_y, end_x, end_y
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [OUT_W-1:0]  m_tdata;          // overlap_cells, cells_marked, segment_rejected, zero pad
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [THR_W-1:0]  cfg_wdata = '0;

    // requests waiting to be sent and results waiting to arrive
    segment_t segment_queue[$];
    tally_t   expected_tally[$];

    // predictor state
    logic [CELL_W-1:0]  coverage_copy [int];
    logic [TOTAL_W-1:0] overlap_copy   = '0;
    logic [THR_W-1:0]   threshold_copy = THR_RESET;

    int mismatches = 0;
    int idle_run   = 0;

    segment_raster_overlap_counter_unit #(
        .GRID_SIDE (GRID_SIDE)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // walk the segment over the coverage copy and return the expected result
    function automatic tally_t rasterise_segment(input segment_t seg);
        tally_t             res;
        int                 x0, y0, x1, y1, dx, dy, len, k, cx, cy, sx, sy, cell_idx;
        logic [CELL_W-1:0]  cnt;
        logic [THR_W-1:0]   thr;
        res = '0;
        x0 = seg.start_x;
        y0 = seg.start_y;
        x1 = seg.end_x;
        y1 = seg.end_y;
        dx = (x0 > x1) ? x0 - x1 : x1 - x0;
        dy = (y0 > y1) ? y0 - y1 : y1 - y0;
        if (dx != 0 && dy != 0 && dx != dy)
        begin
            res.segment_rejected = 1'b1;
        end
        else
        begin
            len = (dx > dy) ? dx : dy;
            sx  = (x1 > x0) ? 1 : ((x1 < x0) ? -1 : 0);
            sy  = (y1 > y0) ? 1 : ((y1 < y0) ? -1 : 0);
            // a zero threshold behaves as one
            thr = (threshold_copy == '0) ? THR_W'(1) : threshold_copy;
            for (k = 0; k <= len; k++)
            begin
                cx = x0 + sx * k;
                cy = y0 + sy * k;
                // cells off the grid are skipped altogether
                if (cx >= 0 && cy >= 0 && cx < GRID_SIDE && cy < GRID_SIDE)
                begin
                    cell_idx = cy * GRID_SIDE + cx;
                    cnt      = coverage_copy.exists(cell_idx) ? coverage_copy[cell_idx] : '0;
                    // saturated cells still count as marked
                    if (cnt != CELL_MAX)
                    begin
                        cnt = cnt + 1'b1;
                        coverage_copy[cell_idx] = cnt;
                        if (cnt == thr)
                            overlap_copy = overlap_copy + 1'b1;
                    end
                    res.cells_marked = res.cells_marked + 1'b1;
                end
            end
        end
        res.overlap_cells = overlap_copy;
        return res;
    endfunction

    task automatic queue_segment(input int x0, input int y0, input int x1, input int y1);
        segment_t seg;
        seg.start_x = COORD_W'(x0);
        seg.start_y = COORD_W'(y0);
        seg.end_x   = COORD_W'(x1);
        seg.end_y   = COORD_W'(y1);
        segment_queue.push_back(seg);
    endtask

    // mostly short lines clustered in a window so that cells overlap, plus long lines,
    // near-diagonal rejects and fully random requests
    task automatic queue_random_segments(input int count);
        int n, pick, len, dir_x, dir_y, x0, y0, wx, wy;
        wx = int'($urandom_range(0, COORD_MAX - 63));
        wy = int'($urandom_range(0, COORD_MAX - 63));
        for (n = 0; n < count; n++)
        begin
            pick = int'($urandom_range(0, 99));
            if (pick >= 88)
            begin
                queue_segment(int'($urandom_range(0, COORD_MAX)), int'($urandom_range(0, COORD_MAX)),
                              int'($urandom_range(0, COORD_MAX)), int'($urandom_range(0, COORD_MAX)));
            end
            else if (pick >= 84)
            begin
                // long line anywhere on the grid
                len   = int'($urandom_range(16, COORD_MAX));
                dir_x = int'($urandom_range(0, 2)) - 1;
                dir_y = int'($urandom_range(0, 2)) - 1;
                x0 = (dir_x > 0) ? int'($urandom_range(0, COORD_MAX - len)) :
                     (dir_x < 0) ? int'($urandom_range(len, COORD_MAX)) :
                                   int'($urandom_range(0, COORD_MAX));
                y0 = (dir_y > 0) ? int'($urandom_range(0, COORD_MAX - len)) :
                     (dir_y < 0) ? int'($urandom_range(len, COORD_MAX)) :
                                   int'($urandom_range(0, COORD_MAX));
                queue_segment(x0, y0, x0 + dir_x * len, y0 + dir_y * len);
            end
            else if (pick >= 76)
            begin
                // diagonal with the end column one off, so it must be rejected
                len   = int'($urandom_range(1, 15));
                dir_x = int'($urandom_range(0, 1)) * 2 - 1;
                dir_y = int'($urandom_range(0, 1)) * 2 - 1;
                x0 = wx + 16 + int'($urandom_range(0, 31));
                y0 = wy + 16 + int'($urandom_range(0, 31));
                queue_segment(x0, y0, x0 + dir_x * (len + 1), y0 + dir_y * len);
            end
            else
            begin
                // short straight or diagonal line inside the window
                len   = int'($urandom_range(0, 15));
                dir_x = int'($urandom_range(0, 2)) - 1;
                dir_y = int'($urandom_range(0, 2)) - 1;
                x0 = wx + 16 + int'($urandom_range(0, 31));
                y0 = wy + 16 + int'($urandom_range(0, 31));
                queue_segment(x0, y0, x0 + dir_x * len, y0 + dir_y * len);
            end
        end
    endtask

    // sender pause: wait until every request is sent and every result is back
    task automatic drain_requests();
        @(negedge clk);
        while (segment_queue.size() != 0 || expected_tally.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_threshold(input logic [THR_W-1:0] value);
        drain_requests();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic log_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    // request driver: bursts of random length with random gaps
    always @(posedge clk)
    begin : request_driver
        logic offer;
        int   burst_left;
        int   gap_left;
        if (rst_n)
        begin
            if (cfg_we)
                threshold_copy = cfg_wdata;
            if (s_tvalid && s_tready)
                expected_tally.push_back(rasterise_segment(segment_queue.pop_front()));
            if (s_tvalid && !s_tready)
            begin
                offer = 1'b1;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                offer = 1'b0;
            end
            else if (segment_queue.size() != 0)
            begin
                offer = 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = int'($urandom_range(1, 24));
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
                end
            end
            else
            begin
                offer = 1'b0;
            end
            s_tvalid <= offer;
            if (offer)
                s_tdata <= IN_W'(segment_queue[0]);
        end
    end

    // result sink: own stall pattern, plus long hold-offs after the 50th and 350th result
    always @(posedge clk)
    begin : result_sink
        logic       take;
        sink_mode_t mode;
        int         mode_left;
        int         results_taken;
        int         holdoff_left;
        int         holdoff_at;
        logic [15:0] stall_pattern;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                results_taken++;
            if (mode_left <= 0)
            begin
                mode          = sink_mode_t'($urandom_range(0, 2));
                mode_left     = int'($urandom_range(20, 80));
                stall_pattern = 16'($urandom);
            end
            mode_left--;
            if (holdoff_left == 0 && holdoff_at != results_taken &&
                (results_taken == 50 || results_taken == 350))
            begin
                holdoff_left = HOLDOFF_CYCLES;
                holdoff_at   = results_taken;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                take = 1'b0;
            end
            else
            begin
                case (mode)
                    SINK_FREE:   take = 1'b1;
                    SINK_RANDOM: take = ($urandom_range(0, 2) != 0);
                    default:
                    begin
                        take          = stall_pattern[0];
                        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
                    end
                endcase
            end
            m_tready <= take;
        end
    end

    // result checker against the oldest prediction
    always @(posedge clk)
    begin : result_check
        tally_t got;
        tally_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(tally_t)-1:0];
            if (expected_tally.size() == 0)
            begin
                log_mismatch($sformatf("result with none expected: total %0d marked %0d rej %0b",
                                       got.overlap_cells, got.cells_marked, got.segment_rejected));
            end
            else
            begin
                want = expected_tally.pop_front();
                if (got.overlap_cells != want.overlap_cells)
                    log_mismatch($sformatf("overlap_cells expected %0d got %0d",
                                           want.overlap_cells, got.overlap_cells));
                if (got.cells_marked != want.cells_marked)
                    log_mismatch($sformatf("cells_marked expected %0d got %0d",
                                           want.cells_marked, got.cells_marked));
                if (got.segment_rejected != want.segment_rejected)
                    log_mismatch($sformatf("segment_rejected expected %0b got %0b",
                                           want.segment_rejected, got.segment_rejected));
            end
        end
    end

    // cycles with no request and no result taken
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
    end

    initial
    begin : watchdog
        wait (idle_run >= WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // reset, directed requests, then random phases over several thresholds
    initial
    begin : sequencer
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single points at both corners
        queue_segment(0, 0, 0, 0);
        queue_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        // full row both ways, full column, both full diagonals, diagonal reversed
        queue_segment(0, 0, COORD_MAX, 0);
        queue_segment(COORD_MAX, 0, 0, 0);
        queue_segment(COORD_MAX, 0, COORD_MAX, COORD_MAX);
        queue_segment(0, 0, COORD_MAX, COORD_MAX);
        queue_segment(COORD_MAX, 0, 0, COORD_MAX);
        queue_segment(COORD_MAX, COORD_MAX, 0, 0);
        // other angles are rejected
        queue_segment(0, 0, 1, 2);
        queue_segment(COORD_MAX, COORD_MAX, 0, 1);
        queue_segment(0, COORD_MAX, COORD_MAX, COORD_MAX - 1);
        queue_segment(512, 512, 513, 514);
        // one cell driven into saturation
        repeat (4) queue_segment(5, 5, 5, 5);
        // leftwards, upwards and the four diagonal directions
        queue_segment(20, 10, 12, 10);
        queue_segment(30, 40, 30, 33);
        queue_segment(100, 100, 107, 107);
        queue_segment(107, 100, 100, 107);
        queue_segment(100, 107, 107, 100);
        queue_segment(107, 107, 100, 100);

        queue_random_segments(100);
        drain_requests();
        queue_random_segments(60);

        set_threshold(2'd3);
        queue_random_segments(100);
        set_threshold(2'd1);
        queue_random_segments(100);
        // zero acts as one
        set_threshold(2'd0);
        queue_random_segments(100);
        set_threshold(THR_RESET);
        queue_random_segments(100);

        drain_requests();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_tally.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
